@@ rtl/yuv420_to_bgr24_converter_assert.svh @@
// ---------------------------------------------------------------------------
// YUV420 to BGR24 converter assertion macros
// Concurrent assertion shorthands, used by the converter's queue.
// ---------------------------------------------------------------------------
`ifndef YUV420_TO_BGR24_CONVERTER_ASSERT_SVH
`define YUV420_TO_BGR24_CONVERTER_ASSERT_SVH

// The condition must never hold while out of reset.
`define YUV_ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

// When the antecedent holds, the consequent must hold in the next cycle.
`define YUV_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/yuv2bgr_pkg.sv @@
// ---------------------------------------------------------------------------
// YUV420 to BGR24 converter package
// Shared types, register indexes and color arithmetic helpers.
// ---------------------------------------------------------------------------
`default_nettype none

package yuv2bgr_pkg;

   // Configuration port geometry.
   localparam int CFG_W     = 12;
   localparam int CSR_IDX_W = 2;

   // Register indexes on the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CHROMA_SWAP  = 2'd2;

   // Register reset values.
   localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 12'd640;
   localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 12'd480;

   // Width used for frame size arithmetic; covers sizes up to 16383.
   localparam int CALC_W = 14;

   // Queue between the front end and the color back end.
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;
   localparam int QCNT_W      = 3;

   // One luma pair with its resolved chroma and row/frame markers.
   typedef struct packed {
      logic [7:0] luma_left;
      logic [7:0] luma_right;
      logic [7:0] chroma_u;
      logic [7:0] chroma_v;
      logic       row_end;
      logic       frame_end;
   } pix_word_type;

   // Chroma sample minus 128 as a signed byte: flip the top bit.
   function automatic logic signed [7:0] chroma_delta(input logic [7:0] c);
      return signed'({~c[7], c[6:0]});
   endfunction

   // Blue offset: floor(129 * du / 64), range -258..255.
   function automatic logic signed [9:0] blue_offset(input logic [7:0] u);
      logic signed [15:0] d;
      logic signed [15:0] p;
      d = 16'(chroma_delta(u));
      p = (d <<< 7) + d;
      return p[15:6];
   endfunction

   // Green offset: floor((3 * du + 6 * dv) / 8), range -144..142.
   function automatic logic signed [9:0] green_offset(input logic [7:0] u,
                                                      input logic [7:0] v);
      logic signed [11:0] du;
      logic signed [11:0] dv;
      logic signed [11:0] g;
      du = 12'(chroma_delta(u));
      dv = 12'(chroma_delta(v));
      g  = (du <<< 1) + du + (dv <<< 2) + (dv <<< 1);
      return {g[11], g[11:3]};
   endfunction

   // Red offset: floor(3 * dv / 2), range -192..190.
   function automatic logic signed [9:0] red_offset(input logic [7:0] v);
      logic signed [9:0] dv;
      logic signed [9:0] r;
      dv = 10'(chroma_delta(v));
      r  = (dv <<< 1) + dv;
      return {r[9], r[9:1]};
   endfunction

   // Clamp a signed sum to a byte.
   function automatic logic [7:0] clamp_byte(input logic signed [10:0] s);
      logic [7:0] res;
      if (s[10]) begin
         res = 8'h00;
      end else if (s[9:8] != 2'b00) begin
         res = 8'hFF;
      end else begin
         res = s[7:0];
      end
      return res;
   endfunction

   // Luma plus a signed offset, clamped.
   function automatic logic [7:0] add_clamp(input logic [7:0] y,
                                            input logic signed [9:0] off);
      return clamp_byte(signed'({3'b000, y}) + 11'(off));
   endfunction

   // Luma minus a signed offset, clamped.
   function automatic logic [7:0] sub_clamp(input logic [7:0] y,
                                            input logic signed [9:0] off);
      return clamp_byte(signed'({3'b000, y}) - 11'(off));
   endfunction

endpackage

`default_nettype wire

@@ rtl/yuv2bgr_front.sv @@
// ---------------------------------------------------------------------------
// YUV420 to BGR24 front end
// Holds the configuration registers, tracks the raster position, keeps the
// chroma line store and hands each word with its resolved chroma to the queue.
// ---------------------------------------------------------------------------
`default_nettype none

module yuv2bgr_front #(
   parameter int MAX_WIDTH  = 2048,
   parameter int MAX_HEIGHT = 2048
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_wr_en,
   input  wire logic [yuv2bgr_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [yuv2bgr_pkg::CFG_W-1:0]     csr_wdata,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic [7:0]                        req_luma_left,
   input  wire logic [7:0]                        req_luma_right,
   input  wire logic [7:0]                        req_chroma_first,
   input  wire logic [7:0]                        req_chroma_second,
   input  wire logic [yuv2bgr_pkg::QCNT_W-1:0]    q_count,
   output logic                                   push_valid,
   output yuv2bgr_pkg::pix_word_type              push_word
);
   import yuv2bgr_pkg::*;

   localparam int LINE_DEPTH = MAX_WIDTH / 2;
   localparam int CW = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
   localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

   logic [CFG_W-1:0]  frame_width_ff;
   logic [CFG_W-1:0]  frame_height_ff;
   logic              chroma_swap_ff;

   logic [CW-1:0]     col_ff;
   logic [CW-1:0]     col_in;
   logic [RW-1:0]     row_ff;
   logic [RW-1:0]     row_in;

   logic              f1_valid_ff;
   logic              f1_odd_ff;
   logic [7:0]        f1_luma_left_ff;
   logic [7:0]        f1_luma_right_ff;
   logic [7:0]        f1_u_ff;
   logic [7:0]        f1_v_ff;
   logic              f1_row_end_ff;
   logic              f1_frame_end_ff;

   logic [15:0]       chroma_line_ff [LINE_DEPTH];
   logic [15:0]       rd_data_ff;

   logic              accept;
   logic              even_row;
   logic [CALC_W-1:0] width_raw;
   logic [CALC_W-1:0] width_clamped;
   logic [CALC_W-1:0] pairs;
   logic [CALC_W-1:0] height_raw;
   logic [CALC_W-1:0] height_clamped;
   logic              last_col;
   logic              last_row;
   logic [7:0]        u_sel;
   logic [7:0]        v_sel;

   // Stall when the queue plus the word in flight would fill the queue.
   assign req_stall = ((QCNT_W + 1)'(q_count) + (QCNT_W + 1)'(f1_valid_ff))
                      >= (QCNT_W + 1)'(QUEUE_DEPTH);
   assign accept    = req_valid && !req_stall;
   assign even_row  = !row_ff[0];

   // Clamp the frame size registers to the supported range.
   always_comb begin
      width_raw  = CALC_W'(frame_width_ff);
      height_raw = CALC_W'(frame_height_ff);
      if (width_raw < CALC_W'(2)) begin
         width_clamped = CALC_W'(2);
      end else if (width_raw > CALC_W'(MAX_WIDTH)) begin
         width_clamped = CALC_W'(MAX_WIDTH);
      end else begin
         width_clamped = width_raw;
      end
      if (height_raw < CALC_W'(1)) begin
         height_clamped = CALC_W'(1);
      end else if (height_raw > CALC_W'(MAX_HEIGHT)) begin
         height_clamped = CALC_W'(MAX_HEIGHT);
      end else begin
         height_clamped = height_raw;
      end
      pairs = width_clamped >> 1;
   end

   // A position at or past the configured size counts as the last one.
   assign last_col = (CALC_W'(col_ff) + CALC_W'(1)) >= pairs;
   assign last_row = (CALC_W'(row_ff) + CALC_W'(1)) >= height_clamped;

   // Raster position update.
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (last_col) begin
            col_in = '0;
            row_in = last_row ? '0 : row_ff + RW'(1);
         end else begin
            col_in = col_ff + CW'(1);
         end
      end
   end

   // Put the input chroma in U, V order.
   assign u_sel = chroma_swap_ff ? req_chroma_second : req_chroma_first;
   assign v_sel = chroma_swap_ff ? req_chroma_first : req_chroma_second;

   // Configuration registers, raster counters and stage valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= FRAME_WIDTH_RST;
         frame_height_ff <= FRAME_HEIGHT_RST;
         chroma_swap_ff  <= 1'b0;
         col_ff          <= '0;
         row_ff          <= '0;
         f1_valid_ff     <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_FRAME_WIDTH:  frame_width_ff  <= csr_wdata;
               CSR_FRAME_HEIGHT: frame_height_ff <= csr_wdata;
               CSR_CHROMA_SWAP:  chroma_swap_ff  <= csr_wdata[0];
               default: begin
               end
            endcase
         end
         col_ff      <= col_in;
         row_ff      <= row_in;
         f1_valid_ff <= accept;
      end
   end

   // Stage payload for the accepted word.
   always_ff @(posedge clock) begin
      if (accept) begin
         f1_odd_ff        <= !even_row;
         f1_luma_left_ff  <= req_luma_left;
         f1_luma_right_ff <= req_luma_right;
         f1_u_ff          <= u_sel;
         f1_v_ff          <= v_sel;
         f1_row_end_ff    <= last_col;
         f1_frame_end_ff  <= last_col && last_row;
      end
   end

   // Chroma line store: even rows write, odd rows read the row above.
   always_ff @(posedge clock) begin
      if (accept && even_row) begin
         chroma_line_ff[col_ff] <= {v_sel, u_sel};
      end
      if (accept && !even_row) begin
         rd_data_ff <= chroma_line_ff[col_ff];
      end
   end

   // Hand the word to the queue with the chroma it should use.
   assign push_valid = f1_valid_ff;
   always_comb begin
      push_word.luma_left  = f1_luma_left_ff;
      push_word.luma_right = f1_luma_right_ff;
      push_word.chroma_u   = f1_odd_ff ? rd_data_ff[7:0]  : f1_u_ff;
      push_word.chroma_v   = f1_odd_ff ? rd_data_ff[15:8] : f1_v_ff;
      push_word.row_end    = f1_row_end_ff;
      push_word.frame_end  = f1_frame_end_ff;
   end

endmodule

`default_nettype wire

@@ rtl/yuv2bgr_queue.sv @@
// ---------------------------------------------------------------------------
// YUV420 to BGR24 word queue
// Short first-in first-out buffer that decouples the front and back ends.
// ---------------------------------------------------------------------------
`default_nettype none

module yuv2bgr_queue (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           push_valid,
   input  wire yuv2bgr_pkg::pix_word_type      push_word,
   input  wire logic                           pop,
   output logic                                head_valid,
   output yuv2bgr_pkg::pix_word_type           head_word,
   output logic [yuv2bgr_pkg::QCNT_W-1:0]      count
);
   import yuv2bgr_pkg::*;
   `include "yuv420_to_bgr24_converter_assert.svh"

   pix_word_type      entries_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff;
   logic [QPTR_W-1:0] rd_ptr_ff;
   logic [QCNT_W-1:0] count_ff;
   logic [QCNT_W-1:0] count_in;

   assign head_valid = (count_ff != '0);
   assign head_word  = entries_ff[rd_ptr_ff];
   assign count      = count_ff;

   // Occupancy follows pushes and pops.
   always_comb begin
      count_in = count_ff;
      if (push_valid && !pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (!push_valid && pop) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   // Pointers and occupancy.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push_valid) begin
            wr_ptr_ff <= wr_ptr_ff + QPTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + QPTR_W'(1);
         end
         count_ff <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push_valid) begin
         entries_ff[wr_ptr_ff] <= push_word;
      end
   end

   // The front end's stall must keep the queue from overflowing.
   `YUV_ASSERT_NEVER(a_no_overflow, clock, reset,
      push_valid && !pop && (count_ff == QCNT_W'(QUEUE_DEPTH)), "queue overflow")
   `YUV_ASSERT_NEVER(a_no_underflow, clock, reset,
      pop && (count_ff == '0), "queue underflow")
   `YUV_ASSERT_NEXT(a_push_counts, clock, reset,
      push_valid && !pop, count_ff == $past(count_ff) + QCNT_W'(1),
      "queue count missed a push")

endmodule

`default_nettype wire

@@ rtl/yuv2bgr_back.sv @@
// ---------------------------------------------------------------------------
// YUV420 to BGR24 back end
// Two-stage color pipeline: chroma offsets, then clamped sums into the
// output register.
// ---------------------------------------------------------------------------
`default_nettype none

module yuv2bgr_back (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 head_valid,
   input  wire yuv2bgr_pkg::pix_word_type head_word,
   output logic                      pop,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic [7:0]                rsp_blue_left,
   output logic [7:0]                rsp_green_left,
   output logic [7:0]                rsp_red_left,
   output logic [7:0]                rsp_blue_right,
   output logic [7:0]                rsp_green_right,
   output logic [7:0]                rsp_red_right,
   output logic                      rsp_row_end,
   output logic                      rsp_frame_end
);
   import yuv2bgr_pkg::*;

   logic              b1_valid_ff;
   logic              b1_valid_in;
   logic [7:0]        b1_luma_left_ff;
   logic [7:0]        b1_luma_right_ff;
   logic signed [9:0] b1_blue_ff;
   logic signed [9:0] b1_green_ff;
   logic signed [9:0] b1_red_ff;
   logic              b1_row_end_ff;
   logic              b1_frame_end_ff;

   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   logic [7:0]        blue_left_ff;
   logic [7:0]        green_left_ff;
   logic [7:0]        red_left_ff;
   logic [7:0]        blue_right_ff;
   logic [7:0]        green_right_ff;
   logic [7:0]        red_right_ff;
   logic              row_end_ff;
   logic              frame_end_ff;

   logic              out_ready;
   logic              b1_ready;

   // Each stage moves when the one after it is empty or moving.
   assign out_ready = !rsp_valid_ff || !rsp_stall;
   assign b1_ready  = !b1_valid_ff || out_ready;
   assign pop       = head_valid && b1_ready;

   always_comb begin
      b1_valid_in  = b1_valid_ff;
      rsp_valid_in = rsp_valid_ff;
      if (b1_ready) begin
         b1_valid_in = head_valid;
      end
      if (out_ready) begin
         rsp_valid_in = b1_valid_ff;
      end
   end

   // Stage valids.
   always_ff @(posedge clock) begin
      if (reset) begin
         b1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         b1_valid_ff  <= b1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Offset stage.
   always_ff @(posedge clock) begin
      if (pop) begin
         b1_luma_left_ff  <= head_word.luma_left;
         b1_luma_right_ff <= head_word.luma_right;
         b1_blue_ff       <= blue_offset(head_word.chroma_u);
         b1_green_ff      <= green_offset(head_word.chroma_u, head_word.chroma_v);
         b1_red_ff        <= red_offset(head_word.chroma_v);
         b1_row_end_ff    <= head_word.row_end;
         b1_frame_end_ff  <= head_word.frame_end;
      end
   end

   // Output register: clamped color sums.
   always_ff @(posedge clock) begin
      if (out_ready && b1_valid_ff) begin
         blue_left_ff   <= add_clamp(b1_luma_left_ff, b1_blue_ff);
         green_left_ff  <= sub_clamp(b1_luma_left_ff, b1_green_ff);
         red_left_ff    <= add_clamp(b1_luma_left_ff, b1_red_ff);
         blue_right_ff  <= add_clamp(b1_luma_right_ff, b1_blue_ff);
         green_right_ff <= sub_clamp(b1_luma_right_ff, b1_green_ff);
         red_right_ff   <= add_clamp(b1_luma_right_ff, b1_red_ff);
         row_end_ff     <= b1_row_end_ff;
         frame_end_ff   <= b1_frame_end_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_blue_left   = blue_left_ff;
   assign rsp_green_left  = green_left_ff;
   assign rsp_red_left    = red_left_ff;
   assign rsp_blue_right  = blue_right_ff;
   assign rsp_green_right = green_right_ff;
   assign rsp_red_right   = red_right_ff;
   assign rsp_row_end     = row_end_ff;
   assign rsp_frame_end   = frame_end_ff;

endmodule

`default_nettype wire

@@ rtl/yuv420_to_bgr24_converter.sv @@
// An accepted word reaches its result word through the front stage and line
// store read, the queue, the offset stage and the output register.
// Throughput: one luma pair per cycle while req_stall is low, set by the
// single-ported line store and the four-entry queue that absorbs output stalls.
// Reset is synchronous: counters, valids and registers (width 640, height 480,
// no chroma swap) are cleared at once; the chroma line store is not cleared.
// ---------------------------------------------------------------------------
// YUV420 to BGR24 converter
// Converts a 4:2:0 raster stream, one luma pair per word, to BGR24 pixels.
// ---------------------------------------------------------------------------
`default_nettype none

module yuv420_to_bgr24_converter #(
   parameter int MAX_WIDTH  = 2048,
   parameter int MAX_HEIGHT = 2048
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_wr_en,
   input  wire logic [yuv2bgr_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [yuv2bgr_pkg::CFG_W-1:0]     csr_wdata,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic [7:0]                        req_luma_left,
   input  wire logic [7:0]                        req_luma_right,
   input  wire logic [7:0]                        req_chroma_first,
   input  wire logic [7:0]                        req_chroma_second,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic [7:0]                             rsp_blue_left,
   output logic [7:0]                             rsp_green_left,
   output logic [7:0]                             rsp_red_left,
   output logic [7:0]                             rsp_blue_right,
   output logic [7:0]                             rsp_green_right,
   output logic [7:0]                             rsp_red_right,
   output logic                                   rsp_row_end,
   output logic                                   rsp_frame_end
);
   import yuv2bgr_pkg::*;

   logic              push_valid;
   pix_word_type      push_word;
   logic              pop;
   logic              head_valid;
   pix_word_type      head_word;
   logic [QCNT_W-1:0] q_count;

   // Front end: configuration, raster position and chroma line store.
   yuv2bgr_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_front (
      .clock             (clock),
      .reset             (reset),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_luma_left     (req_luma_left),
      .req_luma_right    (req_luma_right),
      .req_chroma_first  (req_chroma_first),
      .req_chroma_second (req_chroma_second),
      .q_count           (q_count),
      .push_valid        (push_valid),
      .push_word         (push_word)
   );

   // Queue between the two halves.
   yuv2bgr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_word  (push_word),
      .pop        (pop),
      .head_valid (head_valid),
      .head_word  (head_word),
      .count      (q_count)
   );

   // Back end: color math and output register.
   yuv2bgr_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head_valid      (head_valid),
      .head_word       (head_word),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_blue_left   (rsp_blue_left),
      .rsp_green_left  (rsp_green_left),
      .rsp_red_left    (rsp_red_left),
      .rsp_blue_right  (rsp_blue_right),
      .rsp_green_right (rsp_green_right),
      .rsp_red_right   (rsp_red_right),
      .rsp_row_end     (rsp_row_end),
      .rsp_frame_end   (rsp_frame_end)
   );

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// YUV420 to BGR24 converter testbench
// Drives luma pair words through the converter under random idling on both
// sides, predicts every BGR result word from its own model of the line store
// and raster position, and compares each result word field by field.
// ---------------------------------------------------------------------------

module tb_top;
   import yuv2bgr_pkg::*;

   localparam int CLK_HALF      = 10;
   localparam int RESET_CYCLES  = 11;
   localparam int LIMIT_NS      = 4_000_000;
   localparam int SETTLE_CYCLES = 8;
   localparam int DRAIN_CYCLES  = 5000;
   localparam int LINE_PAIRS    = 1024;
   localparam int MAX_PIXELS    = 2048;
   localparam int MAX_ROWS      = 2048;

   // The fourth register index exists on the port but selects nothing.
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;

   // One converted luma pair as it leaves the block.
   typedef struct packed {
      logic [7:0] blue_left;
      logic [7:0] green_left;
      logic [7:0] red_left;
      logic [7:0] blue_right;
      logic [7:0] green_right;
      logic [7:0] red_right;
      logic       row_end;
      logic       frame_end;
   } bgr_pair_type;

   logic                 clock             = 1'b0;
   logic                 reset             = 1'b1;
   logic                 csr_wr_en         = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index         = CSR_FRAME_WIDTH;
   logic [CFG_W-1:0]     csr_wdata         = '0;
   logic                 req_valid         = 1'b0;
   logic                 req_stall;
   logic [7:0]           req_luma_left     = '0;
   logic [7:0]           req_luma_right    = '0;
   logic [7:0]           req_chroma_first  = '0;
   logic [7:0]           req_chroma_second = '0;
   logic                 rsp_valid;
   logic                 rsp_stall         = 1'b0;
   logic [7:0]           rsp_blue_left;
   logic [7:0]           rsp_green_left;
   logic [7:0]           rsp_red_left;
   logic [7:0]           rsp_blue_right;
   logic [7:0]           rsp_green_right;
   logic [7:0]           rsp_red_right;
   logic                 rsp_row_end;
   logic                 rsp_frame_end;

   // Idle rates in percent for the sending and receiving side.
   int gap_pct   = 31;
   int stall_pct = 72;
   int fail_count = 0;

   // Expected result words, oldest first.
   bgr_pair_type pending_pixels[$];

   // Mirror of the block's registers, line store and raster position.
   logic [CFG_W-1:0] width_setting  = FRAME_WIDTH_RST;
   logic [CFG_W-1:0] height_setting = FRAME_HEIGHT_RST;
   logic             swap_setting   = 1'b0;
   logic [15:0]      chroma_store [LINE_PAIRS];
   int               pair_pos = 0;
   int               row_pos  = 0;

   yuv420_to_bgr24_converter i_dut (
      .clock             (clock),
      .reset             (reset),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_luma_left     (req_luma_left),
      .req_luma_right    (req_luma_right),
      .req_chroma_first  (req_chroma_first),
      .req_chroma_second (req_chroma_second),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_blue_left     (rsp_blue_left),
      .rsp_green_left    (rsp_green_left),
      .rsp_red_left      (rsp_red_left),
      .rsp_blue_right    (rsp_blue_right),
      .rsp_green_right   (rsp_green_right),
      .rsp_red_right     (rsp_red_right),
      .rsp_row_end       (rsp_row_end),
      .rsp_frame_end     (rsp_frame_end)
   );

   always #CLK_HALF clock = ~clock;

   // The receiver stalls at random at the current rate.
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < stall_pct);
   end

   // Effective pairs per row after clamping and rounding down to whole pairs.
   function automatic int active_pairs();
      int w;
      w = width_setting;
      if (w < 2) w = 2;
      if (w > MAX_PIXELS) w = MAX_PIXELS;
      return w / 2;
   endfunction

   // Effective rows per frame after clamping.
   function automatic int active_rows();
      int h;
      h = height_setting;
      if (h < 1) h = 1;
      if (h > MAX_ROWS) h = MAX_ROWS;
      return h;
   endfunction

   function automatic logic [7:0] saturate(input int v);
      if (v < 0) return 8'h00;
      if (v > 255) return 8'hFF;
      return v[7:0];
   endfunction

   // Converts one luma pair and advances the raster position.
   function automatic bgr_pair_type predict_pixels(input logic [7:0] yl, yr, c0, c1);
      bgr_pair_type px;
      logic [7:0] u;
      logic [7:0] v;
      int du;
      int dv;
      int blue_off;
      int green_off;
      int red_off;
      logic last_col;
      logic last_row;

      // Even rows take the word's chroma and save it; odd rows reuse it.
      if (row_pos % 2 == 0) begin
         u = swap_setting ? c1 : c0;
         v = swap_setting ? c0 : c1;
         chroma_store[pair_pos] = {v, u};
      end else begin
         {v, u} = chroma_store[pair_pos];
      end

      // Arithmetic right shifts on signed ints round toward minus infinity.
      du        = int'(u) - 128;
      dv        = int'(v) - 128;
      blue_off  = (du * 129) >>> 6;
      green_off = (du * 3 + dv * 6) >>> 3;
      red_off   = (dv * 3) >>> 1;

      px.blue_left   = saturate(int'(yl) + blue_off);
      px.green_left  = saturate(int'(yl) - green_off);
      px.red_left    = saturate(int'(yl) + red_off);
      px.blue_right  = saturate(int'(yr) + blue_off);
      px.green_right = saturate(int'(yr) - green_off);
      px.red_right   = saturate(int'(yr) + red_off);

      // A position at or past the current size counts as the last one.
      last_col     = (pair_pos + 1 >= active_pairs());
      last_row     = (row_pos + 1 >= active_rows());
      px.row_end   = last_col;
      px.frame_end = last_col && last_row;

      if (last_col) begin
         pair_pos = 0;
         row_pos  = last_row ? 0 : row_pos + 1;
      end else begin
         pair_pos++;
      end
      return px;
   endfunction

   // Words still to send before the current frame wraps.
   function automatic int frame_pairs_left();
      int in_row;
      int rows_after;
      in_row     = active_pairs() - pair_pos;
      rows_after = active_rows() - row_pos - 1;
      if (in_row < 1) in_row = 1;
      if (rows_after < 0) rows_after = 0;
      return in_row + rows_after * active_pairs();
   endfunction

   // Random sample that hits both ends of the range often.
   function automatic logic [7:0] pick_sample();
      case ($urandom_range(0, 7))
         0: return 8'h00;
         1: return 8'hFF;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic logic [CFG_W-1:0] pick_width();
      if ($urandom_range(0, 9) == 0) return CFG_W'($urandom_range(65, 4095));
      return CFG_W'($urandom_range(0, 64));
   endfunction

   function automatic logic [CFG_W-1:0] pick_height();
      if ($urandom_range(0, 9) == 0) return CFG_W'($urandom_range(9, 4095));
      return CFG_W'($urandom_range(0, 8));
   endfunction

   task automatic compare_channel(input string name, input logic [7:0] want,
                                  input logic [7:0] got);
      if (want !== got) begin
         fail_count++;
         $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
      end
   endtask

   // Every accepted result word is checked against the oldest expectation.
   always @(posedge clock) begin : check_words
      bgr_pair_type want;
      bgr_pair_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = {rsp_blue_left, rsp_green_left, rsp_red_left, rsp_blue_right,
                rsp_green_right, rsp_red_right, rsp_row_end, rsp_frame_end};
         if (pending_pixels.size() == 0) begin
            fail_count++;
            $display("%0t: result word with none expected, actual %h", $time, got);
         end else begin
            want = pending_pixels.pop_front();
            compare_channel("blue_left", want.blue_left, got.blue_left);
            compare_channel("green_left", want.green_left, got.green_left);
            compare_channel("red_left", want.red_left, got.red_left);
            compare_channel("blue_right", want.blue_right, got.blue_right);
            compare_channel("green_right", want.green_right, got.green_right);
            compare_channel("red_right", want.red_right, got.red_right);
            compare_channel("row_end", want.row_end, got.row_end);
            compare_channel("frame_end", want.frame_end, got.frame_end);
         end
      end
   end

   // Offers one luma pair word, after a random gap, until it is accepted.
   task automatic send_pair(input logic [7:0] yl, yr, c0, c1);
      while ($urandom_range(0, 99) < gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_luma_left     <= yl;
      req_luma_right    <= yr;
      req_chroma_first  <= c0;
      req_chroma_second <= c1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_pixels.push_back(predict_pixels(yl, yr, c0, c1));
   endtask

   task automatic send_random_pair();
      send_pair(pick_sample(), pick_sample(), pick_sample(), pick_sample());
   endtask

   // Stops sending and waits, with a bound, until every result word is back.
   task automatic settle();
      int n;
      req_valid <= 1'b0;
      n = 0;
      while (pending_pixels.size() != 0 && n < DRAIN_CYCLES) begin
         @(posedge clock);
         n++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Register write; csr_wr_en drops again before the task returns, so back-to-back writes stay apart.
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CFG_W-1:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
      case (idx)
         CSR_FRAME_WIDTH:  width_setting  = value;
         CSR_FRAME_HEIGHT: height_setting = value;
         CSR_CHROMA_SWAP:  swap_setting   = value[0];
         default: ;
      endcase
   endtask

   task automatic program_frame(input logic [CFG_W-1:0] w, h, swap);
      write_reg(CSR_FRAME_WIDTH, w);
      write_reg(CSR_FRAME_HEIGHT, h);
      write_reg(CSR_CHROMA_SWAP, swap);
   endtask

   task automatic finish_frame();
      while (pair_pos != 0 || row_pos != 0) send_random_pair();
   endtask

   // Luma and chroma at both ends of their range, so that every color clamps.
   task automatic test_color_extremes();
      program_frame(12'd6, 12'd2, 12'd0);
      send_pair(8'h00, 8'hFF, 8'h00, 8'h00);
      send_pair(8'hFF, 8'h00, 8'hFF, 8'hFF);
      send_pair(8'h80, 8'h10, 8'h80, 8'h00);
      // The odd row must ignore the chroma that it carries.
      send_pair(8'hFF, 8'h00, 8'h00, 8'hFF);
      send_pair(8'h00, 8'hFF, 8'hFF, 8'h00);
      send_pair(8'h10, 8'hEB, 8'h4D, 8'hC8);
      settle();
   endtask

   // Swapped chroma on one-pair frames; width and height of zero clamp up.
   task automatic test_chroma_swap();
      program_frame(12'd0, 12'd0, 12'hFFF);
      write_reg(CSR_SPARE, 12'hFFF);
      send_pair(8'hFF, 8'h00, 8'h00, 8'hFF);
      send_pair(8'h00, 8'hFF, 8'hFF, 8'h00);
      send_pair(8'h64, 8'hC8, 8'h11, 8'hE6);
      settle();
   endtask

   // Odd width rounds down to two pairs; the odd height leaves a lone even row.
   task automatic test_odd_geometry();
      program_frame(12'd5, 12'd3, 12'hFFE);
      repeat (6) send_random_pair();
      settle();
   endtask

   // Shrinking width and height in mid-frame ends the row and the frame early.
   task automatic test_midframe_resize();
      program_frame(12'd6, 12'd4, 12'd0);
      repeat (8) send_random_pair();
      settle();
      write_reg(CSR_FRAME_WIDTH, 12'd2);
      send_random_pair();
      settle();
      write_reg(CSR_FRAME_HEIGHT, 12'd2);
      send_random_pair();
      settle();
   endtask

   // Oversized registers clamp to the largest frame; one full row fills the
   // line store and the odd row below reads back its first 101 entries.
   task automatic test_widest_row();
      program_frame(12'hFFF, 12'hFFF, 12'd0);
      repeat (LINE_PAIRS + 100) send_random_pair();
      settle();
      write_reg(CSR_FRAME_WIDTH, 12'd200);
      write_reg(CSR_FRAME_HEIGHT, 12'd2);
      send_random_pair();
      settle();
   endtask

   // Bursts of random words under changing geometry, some resized in
   // mid-frame; an odd row is never widened, so it reads saved chroma.
   task automatic test_random_traffic(input int idle_send, input int idle_recv,
                                      input int budget);
      int sent;
      int burst;
      logic [CFG_W-1:0] next_width;
      gap_pct   = idle_send;
      stall_pct = idle_recv;
      sent      = 0;
      while (sent < budget) begin
         settle();
         if ($urandom_range(0, 1) == 0) begin
            // A one-pair, one-row frame wraps at the next word.
            if (frame_pairs_left() > 150) begin
               write_reg(CSR_FRAME_WIDTH, 12'd2);
               write_reg(CSR_FRAME_HEIGHT, 12'd1);
            end
            finish_frame();
            settle();
            next_width = pick_width();
         end else if (row_pos % 2 == 1) begin
            next_width = CFG_W'($urandom_range(0, 2 * active_pairs() + 1));
         end else begin
            next_width = pick_width();
         end
         program_frame(next_width, pick_height(), CFG_W'($urandom_range(0, 4095)));
         burst = $urandom_range(20, 60);
         repeat (burst) send_random_pair();
         sent += burst;
      end
      settle();
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      test_color_extremes();
      test_chroma_swap();
      test_odd_geometry();
      test_midframe_resize();
      test_widest_row();
      test_random_traffic(31, 72, 200);
      test_random_traffic(72, 31, 200);
      test_random_traffic(0, 0, 200);
      settle();
      if (fail_count == 0 && pending_pixels.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   // Guard against a hung handshake.
   initial begin
      #LIMIT_NS;
      $display("status: fail");
      $finish;
   end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/yuv2bgr_pkg.sv
rtl/yuv2bgr_front.sv
rtl/yuv2bgr_queue.sv
rtl/yuv2bgr_back.sv
rtl/yuv420_to_bgr24_converter.sv
tb/tb_top.sv
